>>> hw/rtl/mwe_pkg.sv
// Shared constants, types and codes for the serial EEPROM block.
`timescale 1ns / 1ps
package mwe_pkg;

  localparam int AddrBits  = 6;
  localparam int WordBits  = 16;
  localparam int MemDepth  = 1 << AddrBits;
  localparam int AblW      = $clog2(AddrBits + 1);
  localparam int DblW      = $clog2(WordBits + 1);
  localparam int BitIdxW   = $clog2(WordBits);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [WordBits-1:0] word_t;

  localparam word_t WordOnes = '1;

  // byte register select codes
  localparam logic [1:0] RegDout = 2'd0;
  localparam logic [1:0] RegDin  = 2'd1;
  localparam logic [1:0] RegCs   = 2'd2;

  // bus access kinds
  localparam logic AccRead  = 1'b0;
  localparam logic AccWrite = 1'b1;

  // command opcodes
  localparam logic [1:0] OpExt   = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpErase = 2'd3;

  // extended command codes (top two address bits)
  localparam logic [1:0] ExtWds  = 2'd0;
  localparam logic [1:0] ExtWral = 2'd1;
  localparam logic [1:0] ExtEral = 2'd2;
  localparam logic [1:0] ExtWen  = 2'd3;

  typedef enum logic [6:0] {
    SeqStart   = 7'b0000001,
    SeqOpA     = 7'b0000010,
    SeqOpB     = 7'b0000100,
    SeqAddr    = 7'b0001000,
    SeqData    = 7'b0010000,
    SeqBusy    = 7'b0100000,
    SeqReadout = 7'b1000000
  } seq_state_e;

  typedef enum logic [2:0] {
    RetNone  = 3'd0,
    RetRead  = 3'd1,
    RetExt   = 3'd2,
    RetWaddr = 3'd3,
    RetErase = 3'd4,
    RetWrall = 3'd5,
    RetWrite = 3'd6
  } ret_e;

  typedef struct packed {
    logic  wr_en;
    logic  clr_all;
    addr_t addr;
    word_t wdata;
    word_t fill;
  } mem_cmd_t;

endpackage

>>> hw/rtl/mwe_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module mwe_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mwe_store.sv
// Cell store: RAM plus per-word valid bits and a fill word for bulk writes.
`timescale 1ns / 1ps
module mwe_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mwe_pkg::mem_cmd_t cmd_i,
  input  mwe_pkg::addr_t    raddr_i,
  output mwe_pkg::word_t    word_o
);
  import mwe_pkg::*;

  logic [MemDepth-1:0] valid_q;
  word_t               fill_q;
  logic                rd_valid_q;
  word_t               ram_rdata;

  mwe_ram #(
    .Width(WordBits),
    .Depth(MemDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.addr),
    .wdata_i(cmd_i.wdata),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fill_q     <= WordOnes;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[raddr_i];
      if (cmd_i.clr_all) begin
        valid_q <= '0;
        fill_q  <= cmd_i.fill;
      end else if (cmd_i.wr_en) begin
        valid_q[cmd_i.addr] <= 1'b1;
      end
    end
  end

  assign word_o = rd_valid_q ? ram_rdata : fill_q;

endmodule

>>> hw/rtl/mwe_seq.sv
// Microwire command sequencer: bit decode, counters and store commands.
`timescale 1ns / 1ps
module mwe_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              exec_i,
  input  logic              op_i,
  input  logic [1:0]        sel_i,
  input  logic              din_i,
  input  mwe_pkg::word_t    word_i,
  output mwe_pkg::addr_t    raddr_o,
  output mwe_pkg::mem_cmd_t cmd_o,
  output logic              bit_o
);
  import mwe_pkg::*;

  seq_state_e      seq_q, seq_d;
  ret_e            ret_q, ret_d;
  logic            op_hi_q, op_hi_d;
  addr_t           addr_q, addr_d;
  logic [AblW-1:0] abl_q, abl_d;
  word_t           data_q, data_d;
  logic [DblW-1:0] dbl_q, dbl_d;
  logic            we_q, we_d;
  logic [1:0]      opcode;
  logic            done;

  always_comb begin
    seq_d   = seq_q;
    ret_d   = ret_q;
    op_hi_d = op_hi_q;
    addr_d  = addr_q;
    abl_d   = abl_q;
    data_d  = data_q;
    dbl_d   = dbl_q;
    we_d    = we_q;
    cmd_o   = '0;
    bit_o   = 1'b0;
    opcode  = {op_hi_q, din_i};
    done    = 1'b0;

    if (exec_i) begin
      if (sel_i == RegCs) begin
        seq_d   = SeqStart;
        ret_d   = RetNone;
        op_hi_d = 1'b0;
        addr_d  = '0;
        abl_d   = AblW'(AddrBits);
        data_d  = '0;
        dbl_d   = DblW'(WordBits);
        we_d    = 1'b1;
      end else if (op_i == AccWrite && sel_i == RegDin) begin
        unique case (seq_q)
          SeqStart: seq_d = SeqOpA;
          SeqOpA: begin
            op_hi_d = din_i;
            seq_d   = SeqOpB;
          end
          SeqOpB: begin
            op_hi_d = 1'b0;
            unique case (opcode)
              OpExt:   ret_d = RetExt;
              OpWrite: ret_d = RetWaddr;
              OpRead: begin
                ret_d  = RetRead;
                dbl_d  = DblW'(WordBits);
                data_d = '0;
              end
              default: ret_d = RetErase;
            endcase
            seq_d  = SeqAddr;
            abl_d  = AblW'(AddrBits);
            addr_d = '0;
          end
          SeqAddr: begin
            addr_d = {addr_q[AddrBits-2:0], din_i};
            if (abl_q <= AblW'(1)) begin
              abl_d = '0;
              done  = 1'b1;
            end else begin
              abl_d = abl_q - AblW'(1);
            end
          end
          SeqData: begin
            data_d = {data_q[WordBits-2:0], din_i};
            if (dbl_q <= DblW'(1)) begin
              dbl_d = '0;
              done  = 1'b1;
            end else begin
              dbl_d = dbl_q - DblW'(1);
            end
          end
          default: seq_d = SeqOpA;
        endcase

        if (done) begin
          cmd_o.addr = addr_d;
          unique case (ret_q)
            RetRead: seq_d = SeqReadout;
            RetExt: begin
              unique case (addr_d[AddrBits-1 -: 2])
                ExtWds: begin
                  we_d  = 1'b0;
                  seq_d = SeqStart;
                end
                ExtWral: begin
                  ret_d  = RetWrall;
                  seq_d  = SeqData;
                  dbl_d  = DblW'(WordBits);
                  data_d = '0;
                end
                ExtEral: begin
                  cmd_o.clr_all = we_q;
                  cmd_o.fill    = WordOnes;
                  seq_d         = SeqBusy;
                end
                default: begin
                  we_d  = 1'b1;
                  seq_d = SeqStart;
                end
              endcase
            end
            RetWaddr: begin
              ret_d  = RetWrite;
              seq_d  = SeqData;
              dbl_d  = DblW'(WordBits);
              data_d = '0;
            end
            RetErase: begin
              cmd_o.wr_en = we_q;
              cmd_o.wdata = WordOnes;
              seq_d       = SeqBusy;
            end
            RetWrall: begin
              cmd_o.clr_all = we_q;
              cmd_o.fill    = data_d;
              seq_d         = SeqBusy;
            end
            RetWrite: begin
              cmd_o.wr_en = we_q;
              cmd_o.wdata = data_d;
              seq_d       = SeqBusy;
            end
            default: seq_d = SeqOpA;
          endcase
        end
      end else if (op_i == AccRead && sel_i == RegDout) begin
        bit_o = 1'b1;
        if (seq_q == SeqBusy) begin
          seq_d = SeqStart;
          bit_o = 1'b0;
        end else if (seq_q == SeqReadout) begin
          if (dbl_q > DblW'(WordBits)) begin
            dbl_d = DblW'(WordBits - 1);
          end else if (dbl_q == '0) begin
            dbl_d = '0;
          end else begin
            dbl_d = dbl_q - DblW'(1);
          end
          bit_o = word_i[dbl_d[BitIdxW-1:0]];
          if (dbl_d == '0) begin
            seq_d = SeqStart;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SeqStart;
      ret_q   <= RetNone;
      op_hi_q <= 1'b0;
      addr_q  <= '0;
      abl_q   <= AblW'(AddrBits);
      data_q  <= '0;
      dbl_q   <= DblW'(WordBits);
      we_q    <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      ret_q   <= ret_d;
      op_hi_q <= op_hi_d;
      addr_q  <= addr_d;
      abl_q   <= abl_d;
      data_q  <= data_d;
      dbl_q   <= dbl_d;
      we_q    <= we_d;
    end
  end

  assign raddr_o = addr_q;

endmodule

>>> hw/rtl/microwire_serial_eeprom.sv
// Top level: 64x16 Microwire serial EEPROM behind three byte registers.
// An item accepted at a clock edge executes in the next cycle; done_o and
// read_data_o are registered from the execute cycle, done_o is high for one
// cycle and the result is valid while done_o is high. busy is high in the
// execute cycle, so start is not accepted then; a new item may be accepted
// while done_o reports the last one. Async active-low reset: sequencer to start,
// writes disabled, all words read as ones at once (valid bits cleared, no clearing pass).
`timescale 1ns / 1ps
module microwire_serial_eeprom (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       op_i,
  input  logic [1:0] reg_select_i,
  input  logic [7:0] write_data_i,
  output logic       done_o,
  output logic       read_data_o
);
  import mwe_pkg::*;

  logic       exec_q;
  logic       op_q;
  logic [1:0] sel_q;
  logic       din_q;
  logic       done_q;
  logic       rdata_q;
  logic       accept;
  logic       seq_bit;
  addr_t      raddr;
  word_t      word;
  mem_cmd_t   cmd;

  assign accept = start && !busy;
  assign busy   = exec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q  <= 1'b0;
      done_q  <= 1'b0;
      rdata_q <= 1'b0;
    end else begin
      exec_q  <= accept;
      done_q  <= exec_q;
      rdata_q <= exec_q & seq_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      sel_q <= reg_select_i;
      din_q <= write_data_i[0];
    end
  end

  mwe_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec_q),
    .op_i   (op_q),
    .sel_i  (sel_q),
    .din_i  (din_q),
    .word_i (word),
    .raddr_o(raddr),
    .cmd_o  (cmd),
    .bit_o  (seq_bit)
  );

  mwe_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .raddr_i(raddr),
    .word_o (word)
  );

  assign done_o      = done_q;
  assign read_data_o = rdata_q;

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("busy held for more than one cycle");

  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o) else $error("accepted item gave no result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without executed item");

  a_store_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_en || cmd.clr_all) |-> exec_q && !(cmd.wr_en && cmd.clr_all))
    else $error("store command outside execute cycle");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for microwire_serial_eeprom: byte accesses against a bit-exact model.
`timescale 1ns / 1ps
module tb_top;
  import mwe_pkg::*;

  localparam logic [1:0]  RegNone     = 2'd3;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 510;
  localparam int unsigned MaxPrinted  = 40;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       start        = 1'b0;
  logic       busy;
  logic       op_i         = 1'b0;
  logic [1:0] reg_select_i = 2'd0;
  logic [7:0] write_data_i = 8'd0;
  logic       done_o;
  logic       read_data_o;

  microwire_serial_eeprom DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .reg_select_i(reg_select_i),
    .write_data_i(write_data_i),
    .done_o      (done_o),
    .read_data_o (read_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted EEPROM state
  seq_state_e  ee_seq;
  ret_e        ee_ret;
  logic        ee_chain;
  logic [1:0]  ee_opc;
  addr_t       ee_addr;
  int          ee_abits;
  word_t       ee_shift;
  int          ee_dbits;
  logic        ee_wen;
  word_t       ee_cells [MemDepth];

  logic        dout_expect_q [$];
  int unsigned n_items    = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_commands = 0;
  int unsigned n_programs = 0;
  int unsigned cycle_count = 0;
  logic        idle_on    = 1'b1;

  function automatic void clear_sequencer();
    ee_seq   = SeqStart;
    ee_ret   = RetNone;
    ee_opc   = 2'd0;
    ee_addr  = '0;
    ee_abits = AddrBits;
    ee_shift = '0;
    ee_dbits = WordBits;
  endfunction

  function automatic void fill_cells(input word_t w);
    for (int i = 0; i < MemDepth; i++) ee_cells[i] = w;
  endfunction

  function automatic void model_powerup();
    clear_sequencer();
    ee_wen   = 1'b0;
    ee_chain = 1'b0;
    fill_cells(WordOnes);
  endfunction

  function automatic void load_data(input ret_e target);
    ee_ret   = target;
    ee_seq   = SeqData;
    ee_dbits = WordBits;
    ee_shift = '0;
    ee_chain = 1'b1;
  endfunction

  function automatic void launch(input ret_e target);
    case (target)
      RetExt: begin
        case (ee_addr[AddrBits-1 -: 2])
          ExtWds: begin
            ee_wen = 1'b0;
            ee_seq = SeqStart;
          end
          ExtWral: load_data(RetWrall);
          ExtEral: begin
            if (ee_wen) fill_cells(WordOnes);
            ee_seq = SeqBusy;
          end
          default: begin
            ee_wen = 1'b1;
            ee_seq = SeqStart;
          end
        endcase
      end
      RetWaddr: load_data(RetWrite);
      RetErase: begin
        if (ee_wen) ee_cells[ee_addr] = WordOnes;
        ee_seq = SeqBusy;
      end
      RetWrall: begin
        if (ee_wen) fill_cells(ee_shift);
        ee_seq = SeqBusy;
      end
      RetWrite: begin
        if (ee_wen) ee_cells[ee_addr] = ee_shift;
        ee_seq = SeqBusy;
      end
      default: ee_seq = SeqOpA;
    endcase
  endfunction

  function automatic void phase_complete();
    if (ee_chain) launch(ee_ret);
    else ee_seq = (ee_ret == RetRead) ? SeqReadout : SeqOpA;
  endfunction

  function automatic void shift_in(input logic d);
    case (ee_seq)
      SeqStart: ee_seq = SeqOpA;
      SeqOpA: begin
        ee_opc = {d, 1'b0};
        ee_seq = SeqOpB;
      end
      SeqOpB: begin
        ee_opc[0] = d;
        ee_chain  = 1'b1;
        case (ee_opc)
          OpExt:   ee_ret = RetExt;
          OpWrite: ee_ret = RetWaddr;
          OpRead: begin
            ee_ret   = RetRead;
            ee_chain = 1'b0;
            ee_dbits = WordBits;
            ee_shift = '0;
          end
          default: ee_ret = RetErase;
        endcase
        ee_seq   = SeqAddr;
        ee_abits = AddrBits;
        ee_addr  = '0;
      end
      SeqAddr: begin
        ee_addr = {ee_addr[AddrBits-2:0], d};
        if (ee_abits <= 1) begin
          ee_abits = 0;
          phase_complete();
        end else begin
          ee_abits--;
        end
      end
      SeqData: begin
        ee_shift = {ee_shift[WordBits-2:0], d};
        if (ee_dbits <= 1) begin
          ee_dbits = 0;
          phase_complete();
        end else begin
          ee_dbits--;
        end
      end
      default: ee_seq = SeqOpA;
    endcase
  endfunction

  function automatic logic shift_out();
    logic b;
    b = 1'b1;
    if (ee_seq == SeqBusy) begin
      ee_seq = SeqStart;
      b = 1'b0;
    end else if (ee_seq == SeqReadout) begin
      if (ee_dbits > WordBits) ee_dbits = WordBits;
      if (ee_dbits == 0) ee_dbits = 1;
      ee_dbits--;
      b = ee_cells[ee_addr][ee_dbits];
      if (ee_dbits == 0) ee_seq = SeqStart;
    end
    return b;
  endfunction

  function automatic logic predict_access(input logic acc, input logic [1:0] sel,
                                          input logic [7:0] wd);
    logic r;
    r = 1'b0;
    if (sel == RegCs) begin
      clear_sequencer();
      ee_wen = 1'b1;
    end else if (acc == AccWrite) begin
      if (sel == RegDin) shift_in(wd[0]);
    end else if (sel == RegDout) begin
      r = shift_out();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               dout_expect_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    logic e;
    if (rst_ni && done_o) begin
      if (dout_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result read_data_o=%0b", read_data_o));
      end else begin
        e = dout_expect_q.pop_front();
        if (read_data_o !== e)
          report_mismatch($sformatf("result %0d: read_data_o=%0b, expected %0b",
                                    n_checked, read_data_o, e));
        n_checked++;
      end
    end
  end

  // Drives one item from a falling edge and holds it until accepted.
  task automatic send_access(input logic acc, input logic [1:0] sel, input logic [7:0] wd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    start        = 1'b1;
    op_i         = acc;
    reg_select_i = sel;
    write_data_i = wd;
    do @(posedge clk_i); while (busy);
    dout_expect_q.push_back(predict_access(acc, sel, wd));
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic send_din(input logic d);
    logic [7:0] wd;
    wd    = 8'($urandom);
    wd[0] = d;
    send_access(AccWrite, RegDin, wd);
  endtask

  task automatic poll_dout();
    send_access(AccRead, RegDout, 8'($urandom));
  endtask

  task automatic select_chip();
    send_access(1'($urandom), RegCs, 8'($urandom));
  endtask

  task automatic send_command(input logic [1:0] opc, input addr_t a, input word_t w);
    if (ee_seq != SeqStart && ee_seq != SeqOpA) select_chip();
    if (ee_seq == SeqStart) send_din(1'($urandom));
    send_din(opc[1]);
    send_din(opc[0]);
    for (int i = AddrBits - 1; i >= 0; i--) send_din(a[i]);
    if (opc == OpWrite || (opc == OpExt && a[AddrBits-1 -: 2] == ExtWral))
      for (int i = WordBits - 1; i >= 0; i--) send_din(w[i]);
    n_commands++;
  endtask

  function automatic addr_t pick_addr();
    return $urandom_range(0, 1) ? addr_t'($urandom_range(0, 7)) : addr_t'($urandom);
  endfunction

  function automatic addr_t ext_addr(input logic [1:0] code);
    addr_t a;
    a = addr_t'($urandom);
    a[AddrBits-1 -: 2] = code;
    return a;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WordOnes;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Poll out the busy flag, cut it short with a data-in bit, or leave it pending.
  task automatic settle_program();
    int unsigned r;
    r = $urandom_range(0, 9);
    n_programs++;
    if (r < 7) repeat ($urandom_range(1, 3)) poll_dout();
    else if (r < 9) send_din(1'($urandom));
  endtask

  task automatic read_word();
    case ($urandom_range(0, 5))
      0: begin
        repeat ($urandom_range(0, WordBits - 1)) poll_dout();
        if ($urandom_range(0, 1)) send_din(1'($urandom));
        else select_chip();
      end
      1:       repeat ($urandom_range(WordBits + 1, WordBits + 3)) poll_dout();
      default: repeat (WordBits) poll_dout();
    endcase
  endtask

  task automatic test_register_map();
    send_access(AccRead,  RegDout, 8'h00);
    send_access(AccRead,  RegDin,  8'hFF);
    send_access(AccRead,  RegNone, 8'h00);
    send_access(AccWrite, RegDout, 8'hFF);
    send_access(AccWrite, RegNone, 8'hFF);
    send_access(AccWrite, RegDin,  8'h00);
    send_access(AccRead,  RegCs,   8'hFF);
    send_access(AccWrite, RegCs,   8'h00);
  endtask

  // Read of the top word, cut off mid-word by a data-in bit.
  task automatic test_readout_restart();
    send_command(OpRead, addr_t'(MemDepth - 1), '0);
    repeat (3) poll_dout();
    send_access(AccWrite, RegDin, 8'hFE);
    poll_dout();
  endtask

  // Erase of word 0 left busy, then a data-in bit restarts at the opcode.
  task automatic test_busy_restart();
    send_command(OpErase, '0, '0);
    send_access(AccWrite, RegDin, 8'h01);
    send_din(1'b1);
    send_din(1'b0);
    repeat (AddrBits) send_din(1'b0);
    repeat (2) poll_dout();
  endtask

  task automatic test_random_traffic();
    int unsigned base;
    int unsigned r;
    base = n_items;
    while (n_items - base < RandomItems) begin
      if (n_items - base > RandomItems - 80) idle_on = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_command(OpRead, pick_addr(), '0);
        read_word();
      end else if (r < 45) begin
        send_command(OpWrite, pick_addr(), pick_word());
        settle_program();
      end else if (r < 53) begin
        send_command(OpErase, pick_addr(), '0);
        settle_program();
      end else if (r < 60) begin
        send_command(OpExt, ext_addr(ExtWen), '0);
      end else if (r < 66) begin
        send_command(OpExt, ext_addr(ExtWds), '0);
      end else if (r < 71) begin
        send_command(OpExt, ext_addr(ExtWral), pick_word());
        settle_program();
      end else if (r < 75) begin
        send_command(OpExt, ext_addr(ExtEral), '0);
        settle_program();
      end else if (r < 82) begin
        select_chip();
      end else if (r < 90) begin
        // broken command: start bit and a random run of bits
        send_din(1'($urandom));
        repeat ($urandom_range(1, 20)) send_din(1'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_access(1'($urandom), 2'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    model_powerup();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_map();
    test_readout_restart();
    test_busy_restart();
    test_random_traffic();

    start = 1'b0;
    while (dout_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d byte accesses: %0d serial commands, %0d program/erase cycles.",
             n_items, n_commands, n_programs);
    $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && dout_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mwe_pkg.sv
hw/rtl/mwe_ram.sv
hw/rtl/mwe_store.sv
hw/rtl/mwe_seq.sv
hw/rtl/microwire_serial_eeprom.sv
tb/tb_top.sv
